FILE: src/cbm_pkg.sv
// Shared types, sizes and codes of the cartridge bank mapper.
package cbm_pkg;

    localparam int RAM_BANKS      = 16;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int RAM_DEPTH      = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
    localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
    localparam int RAM_SEL_W      = RAM_ADDR_W - RAM_OFF_W;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int BANK_W     = 9;
    localparam int CNT_W      = 10;
    localparam int ROM_OFF_W  = 14;
    localparam int ROM_ADDR_W = 23;
    localparam int TARGET_W   = 3;

    localparam logic [DATA_W-1:0]  GATE_OPEN     = 8'h0A;
    localparam logic [CNT_W-1:0]   ROM_COUNT_RST = 10'd2;
    localparam logic [DATA_W-1:0]  ROM_LOW_RST   = 8'h01;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [TARGET_W-1:0] TGT_ROM       = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_RAM       = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_RAM_GATED = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_WRITE     = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_UNMAPPED  = 3'd4;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [TARGET_W-1:0]   target;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [DATA_W-1:0]     read_data;
    } t_out_item;

endpackage

FILE: src/cbm_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module cbm_rem_unit
    import cbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BANK_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [BANK_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(BANK_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_count;
    logic [BANK_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;

    always_comb begin
        shifted = {r_rem, r_dvd[BANK_W-1]};
        diff    = shifted - {1'b0, r_div};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = diff[CNT_W-1:0];
        end else begin
            n_rem = shifted[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_count == '0);
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= STEP_W'(BANK_W - 1);
                r_rem   <= '0;
                r_dvd   <= i_dividend;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[BANK_W-2:0], 1'b0};
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[BANK_W-1:0];

endmodule

FILE: src/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: decode, bank registers, cartridge RAM.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_stall     i_in (t_in_item)
//  out       output     o_out_valid / i_out_stall   o_out (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_data (ROM bank count)
//
// A transaction outside the banked ROM and the open cartridge RAM goes straight from
// the idle to the done state, an open cartridge RAM access passes the RAM state of the
// registered RAM read first, and a banked ROM read waits for the nine steps of the
// remainder unit. After reset all 131072 bytes of the cartridge RAM are cleared one
// byte per cycle while o_in_stall stays high; configuration writes are taken throughout.
// A stalled result sits in the output register while the next transaction runs.
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RAM,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [RAM_ADDR_W-1:0] r_clr_addr;
    logic                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic [DATA_W-1:0]     r_wdata;
    logic [DATA_W-1:0]     r_rdata;
    logic [DATA_W-1:0]     r_ram_gate;
    logic [DATA_W-1:0]     r_rom_low;
    logic                  r_rom_high;
    logic [3:0]            r_ram_bank;
    logic [CNT_W-1:0]      r_rom_count;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [DATA_W-1:0] mem [RAM_DEPTH];

    logic                  in_acc;
    logic                  in_rom_banked;
    logic                  in_ram;
    logic                  gate_open;
    logic                  div_start;
    logic                  ram_start;
    logic [BANK_W-1:0]     dividend;
    logic [CNT_W-1:0]      divisor;
    logic                  rem_done;
    logic [BANK_W-1:0]     rem;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic                  mem_we;
    logic [RAM_ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_wdata;
    logic                  out_free;
    t_out_item             result;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc        = i_in_valid && !o_in_stall;
    assign in_rom_banked = (i_in.address[15:14] == 2'b01);
    assign in_ram        = (i_in.address[15:13] == 3'b101);
    assign gate_open     = (r_ram_gate == GATE_OPEN);
    assign div_start     = in_acc && i_in.command == CMD_READ && in_rom_banked;
    assign ram_start     = in_acc && in_ram && gate_open;
    assign dividend      = {r_rom_high, r_rom_low};
    assign divisor       = r_rom_count;
    assign out_free      = !r_out_valid || !i_out_stall;

    cbm_rem_unit u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (dividend),
        .i_divisor   (divisor),
        .o_done      (rem_done),
        .o_remainder (rem)
    );

    assign ram_addr  = {r_ram_bank[RAM_SEL_W-1:0], r_addr[RAM_OFF_W-1:0]};
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_RAM && r_cmd == CMD_WRITE);
    assign mem_addr  = (r_state == S_CLEAR) ? r_clr_addr : ram_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (r_state == S_RAM && r_cmd == CMD_READ) begin
            r_rdata <= mem[ram_addr];
        end
    end

    always_comb begin
        result = '0;
        if (r_cmd == CMD_READ) begin
            if (!r_addr[15]) begin
                result.target = TGT_ROM;
                if (!r_addr[14]) begin
                    result.rom_address = ROM_ADDR_W'(r_addr);
                end else begin
                    result.rom_address = {rem, r_addr[ROM_OFF_W-1:0]};
                end
            end else if (r_addr[15:13] == 3'b101) begin
                if (gate_open) begin
                    result.target    = TGT_RAM;
                    result.read_data = r_rdata;
                end else begin
                    result.target = TGT_RAM_GATED;
                end
            end else begin
                result.target = TGT_UNMAPPED;
            end
        end else begin
            if (r_addr < 16'h6000 || r_addr[15:13] == 3'b101) begin
                result.target = TGT_WRITE;
            end else begin
                result.target = TGT_UNMAPPED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_ram_gate  <= '0;
            r_rom_low   <= ROM_LOW_RST;
            r_rom_high  <= 1'b0;
            r_ram_bank  <= '0;
            r_rom_count <= ROM_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rom_count <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == RAM_ADDR_W'(RAM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd    <= i_in.command;
                        r_addr   <= i_in.address;
                        r_wdata  <= i_in.write_data;
                        if (i_in.command == CMD_WRITE) begin
                            if (i_in.address < 16'h2000) begin
                                r_ram_gate <= i_in.write_data;
                            end else if (i_in.address < 16'h3000) begin
                                r_rom_low <= i_in.write_data;
                            end else if (i_in.address < 16'h4000) begin
                                r_rom_high <= i_in.write_data[0];
                            end else if (i_in.address < 16'h6000) begin
                                r_ram_bank <= i_in.write_data[3:0];
                            end
                        end
                        r_state <= div_start ? S_DIV : (ram_start ? S_RAM : S_DONE);
                    end
                end
                S_DIV: begin
                    if (rem_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_RAM: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out   <= result;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/cbm_checker.sv
// Port-level checker of the cartridge bank mapper and its bind statement.
module cbm_checker
    import cbm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in_item         i_in,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_item        o_out,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CNT_W-1:0] i_cfg_data
);

    // A stalled result transaction must hold.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result transaction changed");

    // The cartridge RAM clear keeps the input stalled right after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // Only one transaction is in work at a time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a transaction is in work");

    // The ROM address is zero for every result that is not a ROM read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.target != TGT_ROM |-> o_out.rom_address == '0)
        else $error("ROM address set on a non-ROM result");

    // Read data is zero for every result that is not an open RAM read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.target != TGT_RAM |-> o_out.read_data == '0)
        else $error("read data set on a result without RAM data");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

FILE: test/cartridge_bank_mapper_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the cartridge bank mapper with a built-in bus decode predictor.
module cartridge_bank_mapper_tb;
    import cbm_pkg::*;

    localparam int unsigned ROM_BANK_SPAN = 32'h4000;
    localparam int unsigned ROM_END       = 32'h8000;
    localparam int unsigned RAM_BASE      = 32'hA000;
    localparam int unsigned RAM_END       = 32'hC000;
    localparam int unsigned BANK_LO_BASE  = 32'h2000;
    localparam int unsigned BANK_HI_BASE  = 32'h3000;
    localparam int unsigned RAM_SEL_END   = 32'h6000;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned DRAIN_CYCLES  = 20;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    logic [CNT_W-1:0]  bank_count;
    logic [DATA_W-1:0] gate_q;
    logic [DATA_W-1:0] bank_lo;
    logic              bank_hi;
    logic [3:0]        ram_sel;
    logic [DATA_W-1:0] shadow_ram [0:RAM_DEPTH-1];

    t_out_item   due_replies[$];
    int          errors;
    int unsigned cycles;
    int          stall_budget;
    bit          reply_taken;
    bit          steady;

    cartridge_bank_mapper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic t_out_item map_bus_access(input t_in_item acc);
        t_out_item   res;
        int unsigned addr;
        int unsigned bank;
        int unsigned slot;
        addr = 32'(acc.address);
        res = '0;
        res.target = TGT_UNMAPPED;
        slot = 0;
        if (addr >= RAM_BASE && addr < RAM_END) begin
            slot = (ram_sel % RAM_BANKS) * RAM_BANK_BYTES + (addr - RAM_BASE) % RAM_BANK_BYTES;
        end
        if (acc.command == CMD_READ) begin
            if (addr < ROM_BANK_SPAN) begin
                res.target = TGT_ROM;
                res.rom_address = ROM_ADDR_W'(addr);
            end else if (addr < ROM_END) begin
                bank = 32'({bank_hi, bank_lo});
                if (bank_count != 0) begin
                    bank = bank % bank_count;
                end
                res.target = TGT_ROM;
                res.rom_address = ROM_ADDR_W'(bank * ROM_BANK_SPAN + (addr - ROM_BANK_SPAN));
            end else if (addr >= RAM_BASE && addr < RAM_END) begin
                if (gate_q == GATE_OPEN) begin
                    res.target = TGT_RAM;
                    res.read_data = shadow_ram[slot];
                end else begin
                    res.target = TGT_RAM_GATED;
                end
            end
        end else begin
            if (addr < BANK_LO_BASE) begin
                gate_q = acc.write_data;
                res.target = TGT_WRITE;
            end else if (addr < BANK_HI_BASE) begin
                bank_lo = acc.write_data;
                res.target = TGT_WRITE;
            end else if (addr < ROM_BANK_SPAN) begin
                bank_hi = acc.write_data[0];
                res.target = TGT_WRITE;
            end else if (addr < RAM_SEL_END) begin
                ram_sel = acc.write_data[3:0];
                res.target = TGT_WRITE;
            end else if (addr >= RAM_BASE && addr < RAM_END) begin
                if (gate_q == GATE_OPEN) begin
                    shadow_ram[slot] = acc.write_data;
                end
                res.target = TGT_WRITE;
            end
        end
        return res;
    endfunction

    function automatic t_in_item bus_op(input logic cmd, input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data);
        t_in_item acc;
        acc.command = cmd;
        acc.address = addr;
        acc.write_data = data;
        return acc;
    endfunction

    function automatic int draw_wait();
        if (steady) begin
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [ADDR_W-1:0] draw_ram_address();
        case ($urandom_range(0, 2))
            0: return ADDR_W'(RAM_BASE + $urandom_range(0, 15));
            1: return ADDR_W'(RAM_BASE + RAM_BANK_BYTES - 1 - $urandom_range(0, 15));
            default: return ADDR_W'(RAM_BASE + $urandom_range(0, RAM_BANK_BYTES - 1));
        endcase
    endfunction

    function automatic t_in_item draw_access();
        int unsigned pick;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        data = DATA_W'($urandom_range(0, 255));
        if (pick < 10) begin
            if ($urandom_range(0, 3) != 0) begin
                data = GATE_OPEN;
            end
            return bus_op(CMD_WRITE, ADDR_W'($urandom_range(0, BANK_LO_BASE - 1)), data);
        end else if (pick < 18) begin
            return bus_op(CMD_WRITE, ADDR_W'($urandom_range(BANK_LO_BASE, BANK_HI_BASE - 1)),
                          data);
        end else if (pick < 23) begin
            return bus_op(CMD_WRITE, ADDR_W'($urandom_range(BANK_HI_BASE, ROM_BANK_SPAN - 1)),
                          data);
        end else if (pick < 30) begin
            return bus_op(CMD_WRITE, ADDR_W'($urandom_range(ROM_BANK_SPAN, RAM_SEL_END - 1)),
                          data);
        end else if (pick < 50) begin
            return bus_op(CMD_WRITE, draw_ram_address(), data);
        end else if (pick < 70) begin
            return bus_op(CMD_READ, draw_ram_address(), data);
        end else if (pick < 88) begin
            return bus_op(CMD_READ, ADDR_W'($urandom_range(0, ROM_END - 1)), data);
        end
        return bus_op(1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 16'hFFFF)), data);
    endfunction

    task automatic send_access(input t_in_item acc);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= acc;
        do @(posedge i_clk); while (o_in_stall);
        due_replies.push_back(map_bus_access(acc));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_bank_count(input logic [CNT_W-1:0] count);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        bank_count = count;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_decode_edges();
        send_access(bus_op(CMD_READ, 16'h0000, 8'h00));
        send_access(bus_op(CMD_READ, 16'h3FFF, 8'hFF));
        send_access(bus_op(CMD_READ, 16'h4000, 8'h00));
        send_access(bus_op(CMD_READ, 16'h7FFF, 8'h00));
        send_access(bus_op(CMD_READ, 16'h8000, 8'h00));
        send_access(bus_op(CMD_READ, 16'h9FFF, 8'h00));
        send_access(bus_op(CMD_READ, 16'hA000, 8'h00));
        send_access(bus_op(CMD_READ, 16'hC000, 8'h00));
        send_access(bus_op(CMD_READ, 16'hFFFF, 8'h00));
        send_access(bus_op(CMD_WRITE, 16'h6000, 8'hFF));
        send_access(bus_op(CMD_WRITE, 16'hFFFF, 8'hFF));
        send_access(bus_op(CMD_WRITE, 16'hA000, 8'h55));
    endtask

    task automatic test_ram_gate();
        send_access(bus_op(CMD_WRITE, 16'h1FFF, GATE_OPEN));
        send_access(bus_op(CMD_WRITE, 16'h5FFF, 8'hFF));
        send_access(bus_op(CMD_WRITE, 16'hBFFF, 8'hA5));
        send_access(bus_op(CMD_READ, 16'hBFFF, 8'h00));
        send_access(bus_op(CMD_WRITE, 16'h4000, 8'h00));
        send_access(bus_op(CMD_READ, 16'hBFFF, 8'h00));
        send_access(bus_op(CMD_READ, 16'hA000, 8'h00));
        send_access(bus_op(CMD_WRITE, 16'h0000, 8'h0B));
        send_access(bus_op(CMD_READ, 16'hBFFF, 8'h00));
    endtask

    task automatic test_rom_banking();
        send_access(bus_op(CMD_WRITE, 16'h2000, 8'hFF));
        send_access(bus_op(CMD_WRITE, 16'h3FFF, 8'hFF));
        send_access(bus_op(CMD_READ, 16'h7FFF, 8'h00));
        wait_drained();
        load_bank_count('0);
        send_access(bus_op(CMD_READ, 16'h4000, 8'h00));
        wait_drained();
        load_bank_count(10'd512);
        send_access(bus_op(CMD_READ, 16'h7FFF, 8'h00));
    endtask

    task automatic test_random_traffic(input logic [CNT_W-1:0] count, input int items,
                                       input bit calm);
        wait_drained();
        load_bank_count(count);
        steady = calm;
        repeat (items) begin
            if ($urandom_range(0, 60) == 0) begin
                wait_drained();
            end
            send_access(draw_access());
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        reply_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (reply_taken) begin
            if (due_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply, expected none, got %p", $time, o_out);
            end else begin
                want = due_replies.pop_front();
                if (o_out !== want) begin
                    errors++;
                    $display("%0t: expected target %0d rom_address %h read_data %h,",
                             $time, want.target, want.rom_address, want.read_data,
                             " got target %0d rom_address %h read_data %h",
                             o_out.target, o_out.rom_address, o_out.read_data);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (reply_taken) begin
            stall_budget = draw_wait();
        end else if (stall_budget > 0) begin
            stall_budget = stall_budget - 1;
        end
        i_out_stall <= (stall_budget > 0);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cartridge_bank_mapper: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = ROM_COUNT_RST;
        errors = 0;
        cycles = 0;
        stall_budget = 0;
        reply_taken = 1'b0;
        steady = 1'b0;
        bank_count = ROM_COUNT_RST;
        gate_q = '0;
        bank_lo = ROM_LOW_RST;
        bank_hi = 1'b0;
        ram_sel = '0;
        for (int i = 0; i < RAM_DEPTH; i++) begin
            shadow_ram[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_decode_edges();
        test_ram_gate();
        test_rom_banking();
        test_random_traffic(10'd512, 115, 1'b0);
        test_random_traffic(10'd1, 115, 1'b1);
        test_random_traffic(10'd0, 115, 1'b0);
        test_random_traffic(10'd1023, 115, 1'b0);
        test_random_traffic(CNT_W'($urandom_range(3, 511)), 115, 1'b1);
        test_random_traffic(10'd2, 115, 1'b0);
        test_random_traffic(10'd3, 115, 1'b0);
        test_random_traffic(CNT_W'($urandom_range(1, 1023)), 115, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("cartridge_bank_mapper: match");
        end else begin
            $display("cartridge_bank_mapper: mismatch");
        end
        $finish;
    end

endmodule
